@@ rtl/aod_pkg.sv @@
// Package: shared constants, codes and types of the orientation detector.
`timescale 1ns / 1ps
`default_nettype none
package aod_pkg;

    // Field and register widths
    localparam int OFS_BITS     = 16;
    localparam int GAIN_BITS    = 20;
    localparam int THR_BITS     = 16;
    localparam int LIM_BITS     = 16;
    localparam int Q8_BITS      = 21;
    localparam int FRAC_BITS    = 16;
    localparam int AXIS_BITS    = 2;
    localparam int STATUS_BITS  = 3;
    localparam int ORIENT_BITS  = 3;
    localparam int SAMPLE_BITS_DEF = 16;

    // Configuration port
    localparam int ADDR_BITS    = 5;
    localparam int DATA_BITS    = 32;
    localparam int REG_IDX_BITS = 3;

    // Register reset values
    localparam logic [GAIN_BITS-1:0] GAIN_RST = GAIN_BITS'(160678);
    localparam logic [LIM_BITS-1:0]  LIM_RST  = LIM_BITS'(2688);

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_OFS_X   = 3'd0,
        REG_OFS_Y   = 3'd1,
        REG_OFS_Z   = 3'd2,
        REG_GAIN    = 3'd3,
        REG_TILT    = 3'd4,
        REG_MAG_LIM = 3'd5
    } t_reg_idx;

    typedef logic [AXIS_BITS-1:0] t_axis;
    localparam t_axis AX_X     = 2'd0;
    localparam t_axis AX_Y     = 2'd1;
    localparam t_axis AX_Z     = 2'd2;
    localparam t_axis AX_OTHER = 2'd3;

    typedef logic [STATUS_BITS-1:0] t_status;
    localparam t_status ST_ROTATED   = 3'd0;
    localparam t_status ST_UNCHANGED = 3'd1;
    localparam t_status ST_MAG_REJ   = 3'd2;
    localparam t_status ST_FACE_UP   = 3'd3;
    localparam t_status ST_FACE_DOWN = 3'd4;
    localparam t_status ST_TIE       = 3'd5;
    localparam t_status ST_DEAD_ZONE = 3'd6;

    typedef logic [ORIENT_BITS-1:0] t_orient;
    localparam t_orient OR_RIGHT    = 3'd0;
    localparam t_orient OR_LEFT     = 3'd1;
    localparam t_orient OR_NORMAL   = 3'd2;
    localparam t_orient OR_INVERTED = 3'd3;
    localparam t_orient OR_UNKNOWN  = 3'd4;

    typedef struct packed {
        logic signed [OFS_BITS-1:0] offset_x;
        logic signed [OFS_BITS-1:0] offset_y;
        logic signed [OFS_BITS-1:0] offset_z;
        logic [GAIN_BITS-1:0]       scale_gain;
        logic [THR_BITS-1:0]        tilt_threshold;
        logic [LIM_BITS-1:0]        magnitude_limit;
    } t_cfg;

endpackage
`default_nettype wire

@@ rtl/aod_cfg.sv @@
// Register file behind the APB-style configuration port.
`timescale 1ns / 1ps
`default_nettype none
module aod_cfg (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [aod_pkg::ADDR_BITS-1:0]   paddr,
    input  wire  [aod_pkg::DATA_BITS-1:0]   pwdata,
    output logic [aod_pkg::DATA_BITS-1:0]   prdata,
    output logic                            pready,
    output aod_pkg::t_cfg                   o_cfg
);
    import aod_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x        <= '0;
            r_cfg.offset_y        <= '0;
            r_cfg.offset_z        <= '0;
            r_cfg.scale_gain      <= GAIN_RST;
            r_cfg.tilt_threshold  <= '0;
            r_cfg.magnitude_limit <= LIM_RST;
        end else if (wr_en) begin
            case (idx)
                REG_OFS_X:   r_cfg.offset_x        <= pwdata[OFS_BITS-1:0];
                REG_OFS_Y:   r_cfg.offset_y        <= pwdata[OFS_BITS-1:0];
                REG_OFS_Z:   r_cfg.offset_z        <= pwdata[OFS_BITS-1:0];
                REG_GAIN:    r_cfg.scale_gain      <= pwdata[GAIN_BITS-1:0];
                REG_TILT:    r_cfg.tilt_threshold  <= pwdata[THR_BITS-1:0];
                REG_MAG_LIM: r_cfg.magnitude_limit <= pwdata[LIM_BITS-1:0];
                default: ;
            endcase
        end
    end

    // offsets read back sign-extended
    always_comb begin
        case (idx)
            REG_OFS_X:   prdata = DATA_BITS'(r_cfg.offset_x);
            REG_OFS_Y:   prdata = DATA_BITS'(r_cfg.offset_y);
            REG_OFS_Z:   prdata = DATA_BITS'(r_cfg.offset_z);
            REG_GAIN:    prdata = DATA_BITS'(r_cfg.scale_gain);
            REG_TILT:    prdata = DATA_BITS'(r_cfg.tilt_threshold);
            REG_MAG_LIM: prdata = DATA_BITS'(r_cfg.magnitude_limit);
            default:     prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/aod_sermul.sv @@
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module aod_sermul #(
    parameter int AW = 21,
    parameter int BW = 21
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire  [AW-1:0]    i_a,
    input  wire  [BW-1:0]    i_b,
    output logic             o_done,
    output logic [AW+BW-1:0] o_prod
);
    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic [PW-1:0] r_a;
    logic [BW-1:0] r_b;
    logic [PW-1:0] r_acc;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(BW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= PW'(i_a);
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier restarted while busy");

endmodule
`default_nettype wire

@@ rtl/accel_orientation_detector.sv @@
// Top level: accelerometer orientation detector with a shared serial multiplier.
// An x/y item is only scaled; a z item is scaled, then x^2, y^2, z^2 and limit^2 are
//   formed, then decided, using the 21-step serial multiplier five times in turn.
// Throughput: one item at a time; the next item is taken once the sequencer is back
//   in idle, while a finished result may still sit in the output register.
// Ignored items (not absolute, or axis code 3) are taken in idle and give no result.
// Reset (synchronous, active low): registers to their defaults, stored axes to zero,
//   orientation to unknown, output register empty.
`timescale 1ns / 1ps
`default_nettype none
module accel_orientation_detector #(
    parameter int SAMPLE_BITS = aod_pkg::SAMPLE_BITS_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // input channel
    input  wire                                i_in_valid,
    output logic                               o_in_stall,
    input  wire                                i_event_is_abs,
    input  wire  [aod_pkg::AXIS_BITS-1:0]      i_axis_code,
    input  wire  signed [SAMPLE_BITS-1:0]      i_sample,
    // output channel
    output logic                               o_out_valid,
    input  wire                                i_out_stall,
    output logic [aod_pkg::STATUS_BITS-1:0]    o_status,
    output logic [aod_pkg::ORIENT_BITS-1:0]    o_current_orientation,
    // configuration port
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire  [aod_pkg::ADDR_BITS-1:0]      paddr,
    input  wire  [aod_pkg::DATA_BITS-1:0]      pwdata,
    output logic [aod_pkg::DATA_BITS-1:0]      prdata,
    output logic                               pready
);
    import aod_pkg::*;

    // difference width: holds sample - offset without overflow
    localparam int DW = ((SAMPLE_BITS > OFS_BITS) ? SAMPLE_BITS : OFS_BITS) + 1;
    // multiplier operand widths: A takes |diff|, |axis| or limit; B gain, |axis| or limit
    localparam int AW = (DW > Q8_BITS) ? DW : Q8_BITS;
    localparam int BW = Q8_BITS;
    localparam int PW = AW + BW;
    localparam int SW = PW + 2;      // room for three squares

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCALE  = 7'b0000010,
        S_SQX    = 7'b0000100,
        S_SQY    = 7'b0001000,
        S_SQZ    = 7'b0010000,
        S_SQL    = 7'b0100000,
        S_DECIDE = 7'b1000000
    } t_state;

    t_cfg cfg;

    aod_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------------------------------------------------------------
    // State
    // ---------------------------------------------------------------------
    t_state                      r_state, n_state;
    t_axis                       r_axis;
    logic                        r_neg;
    logic signed [Q8_BITS-1:0]   r_x, r_y, r_z;
    logic signed [Q8_BITS-1:0]   n_x, n_y, n_z;
    t_orient                     r_orient, n_orient;
    logic [SW-1:0]               r_sum, n_sum;
    logic                        r_out_valid, n_out_valid;
    t_status                     r_out_status, n_out_status;
    t_orient                     r_out_orient, n_out_orient;

    // ---------------------------------------------------------------------
    // Shared serial multiplier
    // ---------------------------------------------------------------------
    logic          mul_start;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic          mul_done;
    logic [PW-1:0] mul_prod;

    aod_sermul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // ---------------------------------------------------------------------
    // Input side: offset removal and magnitude, taken into the multiplier
    // ---------------------------------------------------------------------
    logic                      in_acc;
    logic                      in_useful;
    logic signed [DW-1:0]      in_ofs;
    logic signed [DW-1:0]      in_diff;
    logic [DW-1:0]             in_mag;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign in_useful  = i_event_is_abs && (i_axis_code != AX_OTHER);

    always_comb begin
        case (i_axis_code)
            AX_X:    in_ofs = DW'(cfg.offset_x);
            AX_Y:    in_ofs = DW'(cfg.offset_y);
            default: in_ofs = DW'(cfg.offset_z);
        endcase
    end

    assign in_diff = DW'(i_sample) - in_ofs;
    assign in_mag  = in_diff[DW-1] ? DW'(-in_diff) : DW'(in_diff);

    // ---------------------------------------------------------------------
    // Scaled result: sign back on, floor by 2^16 (arithmetic shift), saturate
    // ---------------------------------------------------------------------
    logic signed [PW:0]        sc_prod;
    logic signed [PW:0]        sc_shift;
    logic                      sc_hi_any, sc_hi_all;
    logic signed [Q8_BITS-1:0] sc_val;

    assign sc_prod   = r_neg ? -$signed({1'b0, mul_prod}) : $signed({1'b0, mul_prod});
    assign sc_shift  = sc_prod >>> FRAC_BITS;
    assign sc_hi_any = |sc_shift[PW:Q8_BITS-1];
    assign sc_hi_all = &sc_shift[PW:Q8_BITS-1];

    always_comb begin
        if (sc_shift[PW] && !sc_hi_all) begin
            sc_val = {1'b1, {(Q8_BITS-1){1'b0}}};
        end else if (!sc_shift[PW] && sc_hi_any) begin
            sc_val = {1'b0, {(Q8_BITS-1){1'b1}}};
        end else begin
            sc_val = sc_shift[Q8_BITS-1:0];
        end
    end

    // ---------------------------------------------------------------------
    // Axis magnitudes and the orientation decision
    // ---------------------------------------------------------------------
    logic [Q8_BITS-1:0]      abs_x, abs_y, abs_z;
    logic signed [Q8_BITS:0] thr_pos, thr_neg;
    logic signed [Q8_BITS:0] dom_val;
    t_orient                 dom_pos, dom_neg, want;
    logic                    over_lim;
    t_status                 dec_status;
    t_orient                 dec_orient;

    assign abs_x   = r_x[Q8_BITS-1] ? Q8_BITS'(-r_x) : Q8_BITS'(r_x);
    assign abs_y   = r_y[Q8_BITS-1] ? Q8_BITS'(-r_y) : Q8_BITS'(r_y);
    assign abs_z   = r_z[Q8_BITS-1] ? Q8_BITS'(-r_z) : Q8_BITS'(r_z);
    assign thr_pos = $signed((Q8_BITS+1)'(cfg.tilt_threshold));
    assign thr_neg = -thr_pos;

    // limit squared sits in the multiplier at decision time
    assign over_lim = r_sum > SW'(mul_prod);

    always_comb begin
        dom_val = (Q8_BITS+1)'(r_y);
        dom_pos = OR_NORMAL;
        dom_neg = OR_INVERTED;
        if (abs_x > abs_y && abs_x > abs_z) begin
            dom_val = (Q8_BITS+1)'(r_x);
            dom_pos = OR_RIGHT;
            dom_neg = OR_LEFT;
        end
        want = (dom_val > thr_pos) ? dom_pos : dom_neg;

        dec_orient = r_orient;
        if (over_lim) begin
            dec_status = ST_MAG_REJ;
        end else if ((abs_x > abs_y && abs_x > abs_z) ||
                     (abs_y > abs_x && abs_y > abs_z)) begin
            if (dom_val > thr_pos || dom_val < thr_neg) begin
                if (r_orient == want) begin
                    dec_status = ST_UNCHANGED;
                end else begin
                    dec_status = ST_ROTATED;
                    dec_orient = want;
                end
            end else begin
                dec_status = ST_DEAD_ZONE;
            end
        end else if (abs_z > abs_x && abs_z > abs_y) begin
            dec_status = (r_z > 0) ? ST_FACE_UP : ST_FACE_DOWN;
        end else begin
            dec_status = ST_TIE;
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer: scale, then for a z item x^2, y^2, z^2, limit^2, decide
    // ---------------------------------------------------------------------
    always_comb begin
        n_state      = r_state;
        n_x          = r_x;
        n_y          = r_y;
        n_z          = r_z;
        n_orient     = r_orient;
        n_sum        = r_sum;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_orient = r_out_orient;
        mul_start    = 1'b0;
        mul_a        = AW'(in_mag);
        mul_b        = BW'(cfg.scale_gain);

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && in_useful) begin
                    mul_start = 1'b1;
                    n_state   = S_SCALE;
                end
            end
            S_SCALE: begin
                mul_a = AW'(abs_x);
                mul_b = abs_x;
                if (mul_done) begin
                    case (r_axis)
                        AX_X:    n_x = sc_val;
                        AX_Y:    n_y = sc_val;
                        default: n_z = sc_val;
                    endcase
                    if (r_axis == AX_Z) begin
                        mul_start = 1'b1;
                        n_state   = S_SQX;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SQX: begin
                mul_a = AW'(abs_y);
                mul_b = abs_y;
                if (mul_done) begin
                    n_sum     = SW'(mul_prod);
                    mul_start = 1'b1;
                    n_state   = S_SQY;
                end
            end
            S_SQY: begin
                mul_a = AW'(abs_z);
                mul_b = abs_z;
                if (mul_done) begin
                    n_sum     = r_sum + SW'(mul_prod);
                    mul_start = 1'b1;
                    n_state   = S_SQZ;
                end
            end
            S_SQZ: begin
                mul_a = AW'(cfg.magnitude_limit);
                mul_b = BW'(cfg.magnitude_limit);
                if (mul_done) begin
                    n_sum     = r_sum + SW'(mul_prod);
                    mul_start = 1'b1;
                    n_state   = S_SQL;
                end
            end
            S_SQL: begin
                if (mul_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                // wait for the output register to be free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = dec_status;
                    n_out_orient = dec_orient;
                    n_orient     = dec_orient;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_x         <= '0;
            r_y         <= '0;
            r_z         <= '0;
            r_orient    <= OR_UNKNOWN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_x         <= n_x;
            r_y         <= n_y;
            r_z         <= n_z;
            r_orient    <= n_orient;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_axis <= i_axis_code;
            r_neg  <= in_diff[DW-1];
        end
        r_sum        <= n_sum;
        r_out_status <= n_out_status;
        r_out_orient <= n_out_orient;
    end

    assign o_out_valid           = r_out_valid;
    assign o_status              = r_out_status;
    assign o_current_orientation = r_out_orient;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_orient_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_orient) |-> (r_out_valid && (r_out_orient == r_orient)))
        else $error("orientation changed without a matching result");

    a_decide_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && !r_out_valid) |=> r_out_valid)
        else $error("decision with free output register gave no result");

    a_mul_done_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state != S_IDLE && r_state != S_DECIDE))
        else $error("multiplier finished outside a multiply step");

endmodule
`default_nettype wire
